// ----- design/a4ks_pkg.sv -----
`timescale 1ns / 1ps

package a4ks_pkg;

  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_AW    = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DISC_W     = 16;
  localparam int unsigned BUDGET_W   = 20;
  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FUNC_W     = 2;

  localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KEY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GEN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEED  = 2'd1;

  localparam logic [DISC_W-1:0]   DISC_RESET   = 16'd3072;
  localparam logic [BUDGET_W-1:0] RESEED_RESET = 20'd400000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_J,
    ST_KEY_WI,
    ST_KEY_WJ,
    ST_B,
    ST_C,
    ST_D,
    ST_EMIT
  } st_e;

  typedef struct packed {
    logic               clr;
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic [PERM_AW-1:0] raddr;
  } mem_req_t;

endpackage

// ----- design/a4ks_perm_mem.sv -----
`timescale 1ns / 1ps

module a4ks_perm_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  a4ks_pkg::mem_req_t         req_i,
  output logic [a4ks_pkg::BYTE_W-1:0] rdata_o
);
  import a4ks_pkg::*;

  logic [BYTE_W-1:0]     mem_q [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] valid_q;
  logic [BYTE_W-1:0]     rd_q;
  logic [PERM_AW-1:0]    raddr_q;
  logic                  vld_q;
  logic                  fwd_q;
  logic [BYTE_W-1:0]     fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // same-edge write wins over the array read
  always_ff @(posedge clk_i) begin
    raddr_q    <= req_i.raddr;
    vld_q      <= valid_q[req_i.raddr];
    fwd_q      <= req_i.we && (req_i.waddr == req_i.raddr);
    fwd_data_q <= req_i.wdata;
  end

  assign rdata_o = fwd_q ? fwd_data_q : (vld_q ? rd_q : raddr_q);

endmodule

// ----- design/a4ks_ctrl.sv -----
`timescale 1ns / 1ps

module a4ks_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [a4ks_pkg::FUNC_W-1:0]   func_i,
  input  logic [a4ks_pkg::BYTE_W-1:0]   key_i,
  input  logic                          last_i,
  input  logic [a4ks_pkg::DISC_W-1:0]   disc_i,
  input  logic [a4ks_pkg::BUDGET_W-1:0] reseed_i,
  input  logic [a4ks_pkg::BYTE_W-1:0]   rdata_i,
  input  logic                          out_free_i,
  output a4ks_pkg::mem_req_t            req_o,
  output logic                          ready_o,
  output logic                          res_vld_o,
  output logic [a4ks_pkg::WORD_W-1:0]   res_word_o,
  output logic                          res_due_o
);
  import a4ks_pkg::*;

  st_e                 st_q, st_d;
  logic [PERM_AW-1:0]  i_q, i_d;
  logic [PERM_AW-1:0]  j_q, j_d;
  logic [BYTE_W-1:0]   a_q, a_d;
  logic [PERM_AW-1:0]  t_q, t_d;
  logic [BYTE_W-1:0]   key_q, key_d;
  logic                last_q, last_d;
  logic                gen_q, gen_d;
  logic [1:0]          bcnt_q, bcnt_d;
  logic [DISC_W-1:0]   dcnt_q, dcnt_d;
  logic [BUDGET_W-1:0] budget_q, budget_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic                due_q, due_d;
  logic [BYTE_W-1:0]   ks_byte;
  logic                spent;

  assign spent   = budget_q <= BUDGET_W'(1);
  assign ks_byte = (t_q == j_q) ? a_q : rdata_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc_i) begin
          if (func_i == FUNC_KEY) begin
            st_d = ST_KEY_J;
          end else if (func_i == FUNC_GEN) begin
            st_d = spent ? ST_EMIT : ST_B;
          end
        end
      end
      ST_KEY_J:  st_d = ST_KEY_WI;
      ST_KEY_WI: st_d = ST_KEY_WJ;
      ST_KEY_WJ: st_d = (last_q && (disc_i != '0)) ? ST_B : ST_IDLE;
      ST_B:      st_d = ST_C;
      ST_C:      st_d = ST_D;
      ST_D: begin
        if (gen_q) begin
          st_d = (bcnt_q == 2'd0) ? ST_EMIT : ST_B;
        end else begin
          st_d = (dcnt_q == DISC_W'(1)) ? ST_IDLE : ST_B;
        end
      end
      ST_EMIT:   st_d = out_free_i ? ST_IDLE : ST_EMIT;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_o     = '0;
    req_o.raddr = i_q;
    ready_o   = 1'b0;
    res_vld_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        ready_o   = 1'b1;
        req_o.clr = acc_i && (func_i == FUNC_INIT);
        req_o.raddr = (func_i == FUNC_GEN) ? i_q + 8'd1 : i_q;
      end
      ST_KEY_J: begin
        req_o.raddr = j_q + rdata_i + key_q;
      end
      ST_KEY_WI: begin
        req_o.we    = 1'b1;
        req_o.waddr = i_q;
        req_o.wdata = rdata_i;
      end
      ST_KEY_WJ: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        req_o.wdata = a_q;
        req_o.raddr = i_q + 8'd1;
      end
      ST_B: begin
        req_o.raddr = j_q + rdata_i;
      end
      ST_C: begin
        req_o.we    = 1'b1;
        req_o.waddr = i_q;
        req_o.wdata = rdata_i;
        req_o.raddr = a_q + rdata_i;
      end
      ST_D: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        req_o.wdata = a_q;
        req_o.raddr = i_q + 8'd1;
      end
      ST_EMIT: begin
        res_vld_o = out_free_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    i_d      = i_q;
    j_d      = j_q;
    a_d      = a_q;
    t_d      = t_q;
    key_d    = key_q;
    last_d   = last_q;
    gen_d    = gen_q;
    bcnt_d   = bcnt_q;
    dcnt_d   = dcnt_q;
    budget_d = budget_q;
    word_d   = word_q;
    due_d    = due_q;
    case (st_q)
      ST_IDLE: begin
        if (acc_i) begin
          case (func_i)
            FUNC_INIT: begin
              i_d      = '0;
              j_d      = '0;
              budget_d = '0;
            end
            FUNC_KEY: begin
              key_d  = key_i;
              last_d = last_i;
            end
            FUNC_GEN: begin
              if (spent) begin
                budget_d = '0;
                word_d   = '0;
                due_d    = 1'b1;
              end else begin
                budget_d = budget_q - BUDGET_W'(1);
                i_d      = i_q + 8'd1;
                bcnt_d   = 2'd3;
                gen_d    = 1'b1;
                due_d    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_KEY_J: begin
        a_d = rdata_i;
        j_d = j_q + rdata_i + key_q;
      end
      ST_KEY_WJ: begin
        if (!last_q) begin
          i_d = i_q + 8'd1;
        end else begin
          j_d = i_q;
          if (disc_i == '0) begin
            budget_d = reseed_i;
          end else begin
            dcnt_d = disc_i;
            gen_d  = 1'b0;
            i_d    = i_q + 8'd1;
          end
        end
      end
      ST_B: begin
        a_d = rdata_i;
        j_d = j_q + rdata_i;
      end
      ST_C: begin
        t_d = a_q + rdata_i;
      end
      ST_D: begin
        if (gen_q) begin
          word_d = {word_q[WORD_W-BYTE_W-1:0], ks_byte};
          if (bcnt_q != 2'd0) begin
            bcnt_d = bcnt_q - 2'd1;
            i_d    = i_q + 8'd1;
          end
        end else if (dcnt_q == DISC_W'(1)) begin
          budget_d = reseed_i;
        end else begin
          dcnt_d = dcnt_q - DISC_W'(1);
          i_d    = i_q + 8'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      budget_q <= '0;
      gen_q    <= 1'b0;
      bcnt_q   <= '0;
      dcnt_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      i_q      <= i_d;
      j_q      <= j_d;
      budget_q <= budget_d;
      gen_q    <= gen_d;
      bcnt_q   <= bcnt_d;
      dcnt_q   <= dcnt_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    t_q    <= t_d;
    key_q  <= key_d;
    word_q <= word_d;
    due_q  <= due_d;
  end

  assign res_word_o = word_q;
  assign res_due_o  = due_q;

endmodule

// ----- design/arc4_keystream_generator_core.sv -----
`timescale 1ns / 1ps

// RC4-style keystream generator with key mixing and a word budget.
// Input stream: tuser selects the function (init, mix key byte, generate word),
// tdata carries the key byte and tlast marks the final key byte. Output stream
// carries one word per generate item: tdata is the keystream word (first byte
// in bits 31:24) and tuser flags an exhausted budget (word is then zero).
// Config port: cfg_idx_i 0 writes discard_bytes, 1 writes reseed_interval.
// Structure: the permutation lives in a 256x8 memory with a registered read;
// each keystream byte passes through the memory states B, C and D. The last
// key byte is followed by discard_bytes discarded keystream bytes. A generate
// item runs accept, four bytes through the memory states, then output load;
// an exhausted budget goes from accept straight to the output load.
// The output register holds a finished word while the receiver stalls; the next
// item is accepted meanwhile, and a generate item waits only to load its word.
// Reset: identity permutation through per-entry valid bits (no clearing pass),
// indices and budget zero, registers at 3072 and 400000.
module arc4_keystream_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // key_byte
  input  logic [a4ks_pkg::FUNC_W-1:0]      s_axis_tuser,  // func
  input  logic                             s_axis_tlast,  // last_key
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [a4ks_pkg::WORD_W-1:0]      m_axis_tdata,  // rand_word
  output logic                             m_axis_tuser,  // reseed_due
  input  logic                             cfg_we_i,
  input  logic [a4ks_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [a4ks_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import a4ks_pkg::*;

  logic [DISC_W-1:0]   disc_q;
  logic [BUDGET_W-1:0] reseed_q;
  logic                ovld_q;
  logic [WORD_W-1:0]   oword_q;
  logic                odue_q;
  mem_req_t            req;
  logic [BYTE_W-1:0]   rdata;
  logic                ready;
  logic                acc;
  logic                out_free;
  logic                res_vld;
  logic [WORD_W-1:0]   res_word;
  logic                res_due;

  assign acc      = s_axis_tvalid && ready;
  assign out_free = !ovld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q   <= DISC_RESET;
      reseed_q <= RESEED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISCARD: disc_q   <= cfg_wdata_i[DISC_W-1:0];
        CFG_RESEED:  reseed_q <= cfg_wdata_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (res_vld) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      oword_q <= res_word;
      odue_q  <= res_due;
    end
  end

  a4ks_perm_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata)
  );

  a4ks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .func_i     (s_axis_tuser),
    .key_i      (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .disc_i     (disc_q),
    .reseed_i   (reseed_q),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .req_o      (req),
    .ready_o    (ready),
    .res_vld_o  (res_vld),
    .res_word_o (res_word),
    .res_due_o  (res_due)
  );

  assign s_axis_tready = ready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = oword_q;
  assign m_axis_tuser  = odue_q;

endmodule

// ----- tb/arc4_keystream_generator_core_tb.sv -----
`timescale 1ns / 1ps

module arc4_keystream_generator_core_tb;
  import a4ks_pkg::*;

  localparam logic [FUNC_W-1:0]    FUNC_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int ITEM_TARGET = 1600;
  localparam int IDLE_PCT    = 18;
  localparam int STALL_LIMIT = 1000000;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              due;
  } rand_word_t;

  class arc4_scoreboard;
    logic [BYTE_W-1:0]   sbox [PERM_DEPTH];
    logic [PERM_AW-1:0]  si;
    logic [PERM_AW-1:0]  sj;
    logic [BUDGET_W-1:0] budget;
    logic [BUDGET_W-1:0] reseed;
    logic [DISC_W-1:0]   discard;
    rand_word_t          words_due [$];
    int                  errors;

    function new();
      errors  = 0;
      discard = DISC_RESET;
      reseed  = RESEED_RESET;
      clear_perm();
    endfunction

    function void clear_perm();
      for (int k = 0; k < PERM_DEPTH; k++) begin
        sbox[k] = k[BYTE_W-1:0];
      end
      si     = '0;
      sj     = '0;
      budget = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_DISCARD: discard = val[DISC_W-1:0];
        CFG_RESEED:  reseed  = val[BUDGET_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [BYTE_W-1:0] next_byte();
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] t;
      si = si + 1'b1;
      a  = sbox[si];
      sj = sj + a;
      b  = sbox[sj];
      sbox[si] = b;
      sbox[sj] = a;
      t = a + b;
      return sbox[t];
    endfunction

    function void note_item(logic [FUNC_W-1:0] fn, logic [BYTE_W-1:0] key, logic last);
      logic [BYTE_W-1:0] val;
      rand_word_t        r;
      case (fn)
        FUNC_INIT: clear_perm();
        FUNC_KEY: begin
          val = sbox[si];
          sj  = sj + val + key;
          sbox[si] = sbox[sj];
          sbox[sj] = val;
          si = si + 1'b1;
          if (last) begin
            si = si - 1'b1;
            sj = si;
            for (int n = 0; n < discard; n++) begin
              void'(next_byte());
            end
            budget = reseed;
          end
        end
        FUNC_GEN: begin
          if (budget <= 1) begin
            budget = '0;
            r.word = '0;
            r.due  = 1'b1;
          end else begin
            budget = budget - 1'b1;
            r.word[31:24] = next_byte();
            r.word[23:16] = next_byte();
            r.word[15:8]  = next_byte();
            r.word[7:0]   = next_byte();
            r.due = 1'b0;
          end
          words_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [WORD_W-1:0] w, logic d);
      rand_word_t e;
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("word %h reseed_due %b with none expected", w, d));
        return;
      end
      e = words_due.pop_front();
      if (w !== e.word) begin
        report_mismatch($sformatf("rand_word %h, expected %h", w, e.word));
      end
      if (d !== e.due) begin
        report_mismatch($sformatf("reseed_due %b, expected %b", d, e.due));
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // key_byte
  logic [FUNC_W-1:0]    s_axis_tuser;   // func
  logic                 s_axis_tlast;   // last_key
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [WORD_W-1:0]    m_axis_tdata;   // rand_word
  logic                 m_axis_tuser;   // reseed_due
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  arc4_scoreboard sb;
  bit             calm;
  int             items_sent;
  int             quiet = 0;

  always #1 clk_i = ~clk_i;

  arc4_keystream_generator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always @(negedge clk_i) begin
    m_axis_tready = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata, m_axis_tuser);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] fn, logic [7:0] key, logic last);
    calm = (items_sent >= 700) && (items_sent < 1000);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 8'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = fn;
    s_axis_tdata  = key;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(fn, key, last);
    if (fn != FUNC_NONE) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain(int extra);
    s_axis_tvalid = 1'b0;
    while (sb.words_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    int               phase;
    int               nseq;
    int               nkey;
    int               klen;
    int               ngen;
    int               n;
    logic [7:0]       keybuf [16];
    logic [CFG_W-1:0] cfg_val;

    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_INIT;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DISCARD;
    cfg_wdata_i   = '0;
    calm          = 1'b0;
    items_sent    = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(FUNC_GEN,  8'hFF, 1'b1);
    send_item(FUNC_NONE, 8'hFF, 1'b1);
    send_item(FUNC_KEY,  8'h00, 1'b0);
    send_item(FUNC_KEY,  8'hFF, 1'b0);
    send_item(FUNC_INIT, 8'hAA, 1'b1);
    send_item(FUNC_GEN,  8'h00, 1'b0);
    send_item(FUNC_KEY,  8'h80, 1'b0);
    send_item(FUNC_KEY,  8'h7F, 1'b0);
    send_item(FUNC_KEY,  8'h01, 1'b1);
    send_item(FUNC_GEN,  8'h00, 1'b0);
    send_item(FUNC_GEN,  8'hFF, 1'b1);
    send_item(FUNC_NONE, 8'h00, 1'b0);
    send_item(FUNC_GEN,  8'h55, 1'b0);
    send_item(FUNC_GEN,  8'hAA, 1'b1);
    send_item(FUNC_INIT, 8'h00, 1'b0);
    send_item(FUNC_GEN,  8'h00, 1'b0);
    drain(3 * sb.discard + 40);

    for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
      case (phase)
        0: begin
          write_cfg(CFG_DISCARD, '0);
          write_cfg(CFG_RESEED, 20'd1);
        end
        1: begin
          write_cfg(CFG_DISCARD, 20'hFFFFF);
          write_cfg(CFG_RESEED, 20'hFFFFF);
        end
        2: begin
          write_cfg(CFG_SPARE_LO, 20'($urandom));
          write_cfg(CFG_SPARE_HI, 20'hFFFFF);
          write_cfg(CFG_DISCARD, 20'd3);
          write_cfg(CFG_RESEED, '0);
        end
        default: begin
          if ($urandom_range(3) != 0) begin
            cfg_val = {4'($urandom), 16'($urandom_range(0, 48))};
            write_cfg(CFG_DISCARD, cfg_val);
          end
          if ($urandom_range(3) != 0) begin
            if ($urandom_range(1) == 0) cfg_val = 20'($urandom_range(1, 8));
            else cfg_val = 20'($urandom_range(9, 1048575));
            write_cfg(CFG_RESEED, cfg_val);
          end
        end
      endcase

      nseq = (phase == 1) ? 1 : $urandom_range(1, 3);
      for (int s = 0; s < nseq; s++) begin
        if (($urandom_range(9) == 0) || (phase == 3 && s == 0)) drain(0);
        if (phase == 1 || $urandom_range(99) < 80) begin
          send_item(FUNC_INIT, 8'($urandom), 1'($urandom));
          if (phase == 1) nkey = $urandom_range(1, 8);
          else if ($urandom_range(7) == 0) nkey = 256;
          else nkey = $urandom_range(1, 40);
          klen = $urandom_range(1, 16);
          for (int k = 0; k < klen; k++) keybuf[k] = 8'($urandom);
          for (int k = 0; k < nkey; k++) begin
            if ($urandom_range(19) == 0) send_item(FUNC_NONE, 8'($urandom), 1'($urandom));
            send_item(FUNC_KEY, keybuf[k % klen], k == nkey - 1);
          end
          ngen = $urandom_range(1, 24);
          for (int g = 0; g < ngen; g++) begin
            send_item(FUNC_GEN, 8'($urandom), 1'($urandom));
          end
        end else begin
          n = $urandom_range(1, 12);
          for (int k = 0; k < n; k++) begin
            send_item(2'($urandom), 8'($urandom), 1'($urandom));
          end
        end
      end
      drain(3 * sb.discard + 40);
    end

    drain(3 * sb.discard + 40);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
